### rtl/roi_pkg.sv
// Package for the ray / oriented box slab intersection unit.
// Shared widths, constants and controller/datapath command and status types.
// No dependencies.
`default_nettype none
package roi_pkg;
    localparam int unsigned CoordW   = 32;
    localparam int unsigned DistW    = 33;
    localparam int unsigned NumW     = 50;
    localparam int unsigned QuotW    = NumW + 16;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned NumRegs  = 6;

    localparam logic [DistW-1:0] FarQ    = 33'd6553600000;
    localparam logic [DistW:0]   FarQ1   = 34'd6553600001;
    localparam logic [NumW-1:0]  FMin    = NumW'(66);
    localparam logic [CoordW-1:0] DirZReset = 32'd65536;

    localparam logic [CfgIdxW-1:0] RegOrgX = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOrgY = 3'd1;
    localparam logic [CfgIdxW-1:0] RegOrgZ = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDirX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDirY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegDirZ = 3'd5;

    typedef struct packed {
        logic load;      // capture input item
        logic mac;       // accumulate one dot-product term
        logic div_start; // start a division
        logic div_sel;   // 0: low plane, 1: high plane
        logic div_step;  // one restoring step
        logic div_store; // store quotient
        logic update;    // narrow interval
        logic emit;      // load output register
    } roi_cmd_t;

    typedef struct packed {
        logic f_big;
        logic last;
        logic missed;
    } roi_sts_t;
endpackage
`default_nettype wire

### rtl/roi_ctrl.sv
// Controller state machine of the slab intersection unit.
// Sequences dot products, the two divisions when |f| is large enough, and the interval update. Uses roi_pkg.
`default_nettype none
module roi_ctrl import roi_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire roi_sts_t sts,
    output roi_cmd_t      cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_DECIDE, ST_DIV, ST_UPDATE, ST_FINISH
    } state_t;

    localparam int unsigned CntW = $clog2(QuotW + 1);

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            sel_reg, sel_next;
    logic            mval_reg, mval_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mval_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        mval_next  = mval_reg && !m_ready;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(2)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.missed || !sts.f_big) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b0;
                    sel_next      = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(QuotW - 1)) begin
                    cmd.div_store = 1'b1;
                    if (sel_reg) begin
                        state_next = ST_UPDATE;
                    end else begin
                        sel_next = 1'b1;
                        cnt_next = '0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIV;
            end
            ST_UPDATE: begin
                // a last slab waits while the output register is still held
                if (!(sts.last && mval_reg && !m_ready)) begin
                    cmd.update = 1'b1;
                    if (sts.last) begin
                        cmd.emit  = 1'b1;
                        mval_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            mval_reg  <= mval_next;
        end
    end
endmodule
`default_nettype wire

### rtl/roi_datapath.sv
// Datapath of the slab intersection unit: ray registers, dot-product MAC,
// restoring divider and interval registers. Uses roi_pkg.
`default_nettype none
module roi_datapath import roi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CfgIdxW-1:0]    cfg_index,
    input  wire logic [CoordW-1:0]     cfg_data,
    input  wire logic signed [CoordW-1:0] s_axis_x,
    input  wire logic signed [CoordW-1:0] s_axis_y,
    input  wire logic signed [CoordW-1:0] s_axis_z,
    input  wire logic signed [CoordW-1:0] s_slab_low,
    input  wire logic signed [CoordW-1:0] s_slab_high,
    input  wire logic signed [CoordW-1:0] s_center_x,
    input  wire logic signed [CoordW-1:0] s_center_y,
    input  wire logic signed [CoordW-1:0] s_center_z,
    input  wire logic                  s_first_slab,
    input  wire logic                  s_last_slab,
    input  wire roi_cmd_t              cmd,
    output roi_sts_t                   sts,
    output logic                       m_hit,
    output logic [DistW-1:0]           m_hit_distance
);
    logic signed [CoordW-1:0] org_reg [3];
    logic signed [CoordW-1:0] dir_reg [3];
    logic signed [CoordW-1:0] ax_reg [3];
    logic signed [CoordW-1:0] ce_reg [3];
    logic signed [CoordW-1:0] lo_reg, hi_reg;
    logic first_reg, last_reg;
    logic [1:0] term_reg;
    logic signed [NumW-1:0] e_reg, f_reg;
    logic [DistW-1:0] near_reg, far_reg;
    logic missed_reg;
    logic signed [DistW+1:0] t1_reg, t2_reg;
    // divider
    logic [NumW-1:0] dden_reg;
    logic [NumW:0]   rem_reg;
    logic [QuotW-1:0] quo_reg;
    logic [QuotW-1:0] shf_reg;
    logic            neg_reg;
    logic hit_reg;
    logic [DistW-1:0] dist_reg;

    // term products
    logic signed [CoordW:0]      diff;
    logic signed [2*CoordW:0]    pe;
    logic signed [2*CoordW-1:0]  pf;
    logic signed [NumW-1:0]      e_term, f_term;
    always_comb begin
        diff = {ce_reg[term_reg][CoordW-1], ce_reg[term_reg]}
             - {org_reg[term_reg][CoordW-1], org_reg[term_reg]};
        pe = ax_reg[term_reg] * diff;
        pf = dir_reg[term_reg] * ax_reg[term_reg];
        e_term = NumW'(pe >>> 16);
        f_term = NumW'(pf >>> 16);
    end

    // effective interval after optional clear
    logic [DistW-1:0] near_eff, far_eff;
    logic missed_eff;
    assign near_eff   = first_reg ? '0 : near_reg;
    assign far_eff    = first_reg ? FarQ : far_reg;
    assign missed_eff = first_reg ? 1'b0 : missed_reg;

    logic [NumW-1:0] abs_f;
    assign abs_f = f_reg[NumW-1] ? NumW'(-f_reg) : NumW'(f_reg);
    assign sts.f_big  = abs_f >= FMin;
    assign sts.last   = last_reg;
    assign sts.missed = missed_eff;

    // numerator for division
    logic signed [NumW-1:0] num_sel;
    assign num_sel = e_reg + NumW'(cmd.div_sel ? hi_reg : lo_reg);

    // restoring step on {an, 16 zero bits}
    logic [NumW:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg[NumW-1:0], shf_reg[QuotW-1]};
    assign rem_sub = rem_sh - {1'b0, dden_reg};

    // quotient to clamped distance
    logic [DistW:0] mag;
    logic signed [DistW+1:0] tq;
    always_comb begin
        logic [QuotW-1:0] q;
        q = rem_sub[NumW] ? {quo_reg[QuotW-2:0], 1'b0} : {quo_reg[QuotW-2:0], 1'b1};
        mag = (q > QuotW'(FarQ1)) ? FarQ1 : q[DistW:0];
        if (neg_reg) begin
            tq = (mag != '0) ? -(DistW+2)'(1) : '0;
        end else begin
            tq = (DistW+2)'(mag);
        end
    end

    // interval update
    logic signed [DistW+1:0] tn, tf, near_s, far_s;
    logic [DistW-1:0] near_new, far_new;
    logic missed_new;
    always_comb begin
        tn = (t1_reg > t2_reg) ? t2_reg : t1_reg;
        tf = (t1_reg > t2_reg) ? t1_reg : t2_reg;
        near_s = $signed({2'b00, near_eff});
        far_s  = $signed({2'b00, far_eff});
        near_new = near_eff;
        far_new  = far_eff;
        missed_new = missed_eff;
        if (!missed_eff) begin
            if (sts.f_big) begin
                if (tf < far_s) far_s = tf;
                if (tn > near_s) near_s = tn;
                far_new  = far_s[DistW-1:0];
                near_new = near_s[DistW-1:0];
                if (far_s < near_s) missed_new = 1'b1;
            end else begin
                if ((lo_reg > e_reg) || (hi_reg < e_reg)) missed_new = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0; org_reg[1] <= '0; org_reg[2] <= '0;
            dir_reg[0] <= '0; dir_reg[1] <= '0; dir_reg[2] <= DirZReset;
            near_reg <= '0;
            far_reg  <= FarQ;
            missed_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    RegOrgX: org_reg[0] <= cfg_data;
                    RegOrgY: org_reg[1] <= cfg_data;
                    RegOrgZ: org_reg[2] <= cfg_data;
                    RegDirX: dir_reg[0] <= cfg_data;
                    RegDirY: dir_reg[1] <= cfg_data;
                    RegDirZ: dir_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.update) begin
                if (last_reg) begin
                    near_reg <= '0;
                    far_reg  <= FarQ;
                    missed_reg <= 1'b0;
                end else begin
                    near_reg <= near_new;
                    far_reg  <= far_new;
                    missed_reg <= missed_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg[0] <= s_axis_x; ax_reg[1] <= s_axis_y; ax_reg[2] <= s_axis_z;
            ce_reg[0] <= s_center_x; ce_reg[1] <= s_center_y; ce_reg[2] <= s_center_z;
            lo_reg <= s_slab_low;
            hi_reg <= s_slab_high;
            first_reg <= s_first_slab;
            last_reg  <= s_last_slab;
            term_reg  <= '0;
            e_reg <= '0;
            f_reg <= '0;
        end
        if (cmd.mac) begin
            e_reg <= e_reg + e_term;
            f_reg <= f_reg + f_term;
            term_reg <= term_reg + 1'b1;
        end
        if (cmd.div_start) begin
            dden_reg <= abs_f;
            neg_reg  <= num_sel[NumW-1] != f_reg[NumW-1];
            rem_reg  <= '0;
            quo_reg  <= '0;
            shf_reg  <= {num_sel[NumW-1] ? NumW'(-num_sel) : NumW'(num_sel), 16'd0};
        end
        if (cmd.div_step) begin
            rem_reg <= rem_sub[NumW] ? rem_sh : rem_sub;
            quo_reg <= {quo_reg[QuotW-2:0], ~rem_sub[NumW]};
            shf_reg <= {shf_reg[QuotW-2:0], 1'b0};
        end
        if (cmd.div_store) begin
            if (cmd.div_sel) t2_reg <= tq;
            else             t1_reg <= tq;
        end
        if (cmd.emit) begin
            hit_reg  <= !missed_new;
            dist_reg <= missed_new ? '0 : near_new;
        end
    end

    assign m_hit = hit_reg;
    assign m_hit_distance = dist_reg;
endmodule
`default_nettype wire

### rtl/ray_obb_slab_intersection_unit.sv
// Ray / oriented box slab intersection unit, top level.
// Joins roi_ctrl and roi_datapath; uses roi_pkg.
//
// A ray is set through a write port (cfg_we, cfg_index, cfg_data): origin
// x/y/z at indexes 0..2, direction x/y/z at 3..5, signed Q16.16. Write it
// only while no slab is in flight.
// Boxes arrive on the s_ channel as slab transfers, one per box axis, with
// first_slab and last_slab framing the box. The slab on last_slab yields one
// m_ transfer carrying hit and the Q17.16 near distance.
// Slabs are taken one at a time: the three MAC terms, a decide state, then,
// when |f| is large enough, two 66 step restoring divisions in the shared
// divider with a start state between them, then the interval update.
// m_valid rises after the update state of a last slab, and the next slab is
// taken only once the previous slab has been updated.
// A result held in the output register does not block s_ready; only the
// update cycle of a following last slab waits until m_ready takes it.
// Reset (aresetn low, synchronous) restores ray origin 0, direction
// (0, 0, 1.0), the initial interval [0, 100000] and an empty output register.
`default_nettype none
module ray_obb_slab_intersection_unit import roi_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIdxW-1:0]       cfg_index,
    input  wire logic [CoordW-1:0]        cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [CoordW-1:0] s_axis_x,
    input  wire logic signed [CoordW-1:0] s_axis_y,
    input  wire logic signed [CoordW-1:0] s_axis_z,
    input  wire logic signed [CoordW-1:0] s_slab_low,
    input  wire logic signed [CoordW-1:0] s_slab_high,
    input  wire logic signed [CoordW-1:0] s_center_x,
    input  wire logic signed [CoordW-1:0] s_center_y,
    input  wire logic signed [CoordW-1:0] s_center_z,
    input  wire logic                     s_first_slab,
    input  wire logic                     s_last_slab,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_hit,
    output logic [DistW-1:0]              m_hit_distance
);
    roi_cmd_t cmd;
    roi_sts_t sts;

    roi_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    roi_datapath u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_axis_x, .s_axis_y, .s_axis_z, .s_slab_low, .s_slab_high,
        .s_center_x, .s_center_y, .s_center_z, .s_first_slab, .s_last_slab,
        .cmd, .sts, .m_hit, .m_hit_distance
    );

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hit) && $stable(m_hit_distance)))
        else $error("result changed while stalled");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_hit_distance == '0)) else $error("miss with distance");
    a_dist_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit_distance <= FarQ)) else $error("distance above far bound");
endmodule
`default_nettype wire

### tb/ray_obb_slab_intersection_unit_test.sv
// Testbench for ray_obb_slab_intersection_unit: slab items are driven over valid/ready,
// and a scoreboard class predicts the hit and the near distance of each box and checks them.
// Depends on roi_pkg and the unit's RTL.
`timescale 1ns / 100ps
`default_nettype none
module ray_obb_slab_intersection_unit_test import roi_pkg::*;;

    typedef struct packed {
        logic signed [31:0] axis_x, axis_y, axis_z, lo, hi, cx, cy, cz;
        logic first, last;
    } slab_t;

    class box_scoreboard;
        longint ray [NumRegs];
        longint near_lim, far_lim;
        bit missed;
        logic [DistW:0] pending [$];
        int errors;

        function new();
            for (int i = 0; i < NumRegs; i++) ray[i] = 0;
            ray[RegDirZ] = 65536;
            clear_interval();
            errors = 0;
        endfunction

        function void clear_interval();
            near_lim = 0;
            far_lim = 64'sd6553600000;
            missed = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            if (idx < NumRegs) ray[idx] = longint'($signed(v));
        endfunction

        function longint floor_q16(longint p);
            return p >>> 16;
        endfunction

        function longint plane_dist(longint num, longint den);
            longint unsigned an, ad, q, r, mag;
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            q = an / ad;
            r = an % ad;
            if (q > 100000) mag = 64'd6553600001;
            else begin
                mag = (q << 16) + ((r << 16) / ad);
                if (mag > 64'd6553600001) mag = 64'd6553600001;
            end
            if ((num < 0) != (den < 0)) return mag != 0 ? -1 : 0;
            return longint'(mag);
        endfunction

        function void note_slab(slab_t s);
            longint ax [3], ce [3];
            longint e, f, t1, t2, w, lo, hi;
            ax[0] = s.axis_x; ax[1] = s.axis_y; ax[2] = s.axis_z;
            ce[0] = s.cx; ce[1] = s.cy; ce[2] = s.cz;
            lo = s.lo; hi = s.hi;
            e = 0; f = 0;
            if (s.first) clear_interval();
            if (!missed) begin
                for (int i = 0; i < 3; i++) begin
                    e += floor_q16(ax[i] * (ce[i] - ray[i]));
                    f += floor_q16(ray[3 + i] * ax[i]);
                end
                if (f >= 66 || f <= -66) begin
                    t1 = plane_dist(e + lo, f);
                    t2 = plane_dist(e + hi, f);
                    if (t1 > t2) begin w = t1; t1 = t2; t2 = w; end
                    if (t2 < far_lim) far_lim = t2;
                    if (t1 > near_lim) near_lim = t1;
                    if (far_lim < near_lim) missed = 1;
                end else if (lo - e > 0 || hi - e < 0) missed = 1;
            end
            if (s.last) begin
                pending.insert(pending.size(), {!missed, missed ? 33'd0 : near_lim[32:0]});
                clear_interval();
            end
        endfunction

        function void check_result(logic h, logic [DistW-1:0] d);
            logic [DistW:0] exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result hit=%0b dist=%0d", $time, h, d);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (h !== exp_r[DistW])
                $display("%0t: hit expected %0b actual %0b", $time, exp_r[DistW], h);
            if (d !== exp_r[DistW-1:0])
                $display("%0t: hit_distance expected %0d actual %0d",
                         $time, exp_r[DistW-1:0], d);
            if (h !== exp_r[DistW] || d !== exp_r[DistW-1:0]) errors++;
        endfunction
    endclass

    logic aclk, aresetn, cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CoordW-1:0] cfg_data;
    logic s_valid, s_ready, m_valid, m_ready, m_hit;
    logic signed [CoordW-1:0] s_axis_x, s_axis_y, s_axis_z, s_slab_low, s_slab_high;
    logic signed [CoordW-1:0] s_center_x, s_center_y, s_center_z;
    logic s_first_slab, s_last_slab;
    logic [DistW-1:0] m_hit_distance;

    box_scoreboard sb;
    int src_idle, sink_idle, hold_off;

    ray_obb_slab_intersection_unit uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_hit, m_hit_distance);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else
            m_ready <= ($urandom_range(99) >= sink_idle);
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $signed($urandom_range(2 * 65536 * 200)) - 65536 * 200;
        endcase
    endfunction

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(40);
            default: return $signed($urandom_range(131072)) - 65536;
        endcase
    endfunction

    task automatic send_slab(slab_t s);
        @(posedge aclk);
        while ($urandom_range(99) < src_idle) @(posedge aclk);
        s_valid <= 1;
        {s_axis_x, s_axis_y, s_axis_z, s_slab_low, s_slab_high,
         s_center_x, s_center_y, s_center_z, s_first_slab, s_last_slab} <= s;
        do @(posedge aclk); while (!s_ready);
        sb.note_slab(s);
        s_valid <= 0;
    endtask

    task automatic send_box(int n, bit frame);
        slab_t s;
        for (int i = 0; i < n; i++) begin
            s.axis_x = rand_axis(); s.axis_y = rand_axis(); s.axis_z = rand_axis();
            s.lo = rand_val(); s.hi = rand_val();
            if ($urandom_range(3) != 0) begin
                s.lo = -$signed(32'($urandom_range(65536 * 50)));
                s.hi = $urandom_range(65536 * 50);
            end
            s.cx = rand_val(); s.cy = rand_val(); s.cz = rand_val();
            s.first = frame ? (i == 0) : 1'($urandom_range(1));
            s.last = frame ? (i == n - 1) : ($urandom_range(3) == 0);
            send_slab(s);
        end
    endtask

    task automatic drain_and_config(int mode);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        for (int i = 0; i < NumRegs + 2; i++) begin
            cfg_we <= 1;
            cfg_index <= i[CfgIdxW-1:0];
            case (mode)
                0: cfg_data <= (i >= 3) ? 32'h8000_0000 : 32'h7fff_ffff;
                1: cfg_data <= (i < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
                default: cfg_data <= (i < 3) ? rand_val() : rand_axis();
            endcase
            @(posedge aclk);
            sb.set_reg(i, cfg_data);
        end
        cfg_we <= 0;
    endtask

    initial begin
        slab_t s;
        sb = new();
        aresetn = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; m_ready = 0; hold_off = 0;
        {s_axis_x, s_axis_y, s_axis_z, s_slab_low, s_slab_high,
         s_center_x, s_center_y, s_center_z, s_first_slab, s_last_slab} = '0;
        src_idle = 32; sink_idle = 48;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset ray along z, unit box, parallel slabs, extremes
        s = '0; s.axis_z = 65536; s.lo = -65536; s.hi = 65536; s.cz = 5 << 16;
        s.first = 1; s.last = 1; send_slab(s);
        s.axis_z = 0; s.axis_x = 65536; s.cx = 3 << 16; send_slab(s);
        s.cx = 0; send_slab(s);
        s.axis_x = 0; s.axis_z = -65536; s.cz = -(5 << 16); send_slab(s);
        s = '1; s.axis_x = 32'h8000_0000; s.lo = 32'h8000_0000; s.hi = 32'h7fff_ffff;
        send_slab(s);
        s = '0; s.axis_z = 65536; s.lo = 65536; s.hi = 65536; s.cz = 32'h7fff_ffff;
        s.first = 1; s.last = 0; send_slab(s);
        s.axis_z = 65; s.first = 0; send_slab(s);
        s.axis_z = 66; s.last = 1; send_slab(s);
        s.axis_z = -66; s.first = 1; send_slab(s);
        drain_and_config(0);
        send_box(6, 1);
        drain_and_config(1);
        send_box(6, 1);
        drain_and_config(2);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin src_idle = 48; sink_idle = 32; end
            if (ph == 2) begin src_idle = 0; sink_idle = 0; end
            for (int b = 0; b < 190; b++) begin
                if (b == 40) hold_off = 3000;
                if (b % 30 == 29) drain_and_config(2);
                if ($urandom_range(9) == 0) send_box($urandom_range(1, 4), 0);
                else send_box($urandom_range(1, 3) == 1 ? $urandom_range(1, 4) : 3, 1);
            end
        end
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
